FILE: src/c2d_pkg.sv
// Shared types, codes and defaults for the 2D convolution engine.
`timescale 1ns / 1ps

package c2d_pkg;

	// Default sizes for the top-level parameters
	localparam int DEF_MAX_IMAGE_SIDE  = 64;
	localparam int DEF_MAX_KERNEL_SIDE = 7;
	localparam int DEF_SAMPLE_BITS     = 16;

	// Fixed field widths
	localparam int SUM_BITS      = 40;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 7;

	// Input opcodes
	localparam logic [1:0] OP_WR_WEIGHT = 2'd0;
	localparam logic [1:0] OP_WR_PIXEL  = 2'd1;
	localparam logic [1:0] OP_COMPUTE   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] CFG_KERNEL_SIDE = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_SIZE   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_PAD_WIDTH   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_ROWS  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_COLS  = 3'd4;

	// Configuration reset values
	localparam logic [2:0] RST_KERNEL_SIDE = 3'd3;
	localparam logic [2:0] RST_STEP_SIZE   = 3'd1;
	localparam logic [1:0] RST_PAD_WIDTH   = 2'd0;
	localparam logic [6:0] RST_IMAGE_ROWS  = 7'd32;
	localparam logic [6:0] RST_IMAGE_COLS  = 7'd32;

	typedef struct packed {
		logic [2:0] kernel_side;
		logic [2:0] step_size;
		logic [1:0] pad_width;
		logic [6:0] image_rows;
		logic [6:0] image_cols;
	} cfg_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clear;
		logic valid;
	} mac_ctl_t;

endpackage

FILE: src/c2d_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module c2d_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 16,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: src/c2d_mac.sv
// Shared multiply-accumulate unit: one pixel-times-weight product per cycle.
`timescale 1ns / 1ps

module c2d_mac #(
	parameter int SAMPLE_BITS = c2d_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  c2d_pkg::mac_ctl_t                   ctl,
	input  logic [SAMPLE_BITS-1:0]              pix,
	input  logic [SAMPLE_BITS-1:0]              wgt,
	output logic signed [c2d_pkg::SUM_BITS-1:0] acc
);

	import c2d_pkg::*;

	localparam int PW = 2 * SAMPLE_BITS;
	localparam int EW = (PW > SUM_BITS) ? PW : SUM_BITS;

	logic signed [PW-1:0] prod_s2;
	logic                 vld_s2;
	logic signed [EW-1:0] prod_ext;
	logic signed [SUM_BITS-1:0] acc_q;

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(pix) * $signed(wgt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.valid;
		end
	end

	assign prod_ext = EW'(prod_s2);

	// Sum wraps at the output width, so a truncated product adds the same
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + SUM_BITS'(prod_ext);
		end
	end

	assign acc = acc_q;

endmodule

FILE: src/c2d_seq.sv
// Sequencer: store writes, grid check, kernel tap walk and result register.
`timescale 1ns / 1ps

module c2d_seq #(
	parameter int MAX_IMAGE_SIDE  = c2d_pkg::DEF_MAX_IMAGE_SIDE,
	parameter int MAX_KERNEL_SIDE = c2d_pkg::DEF_MAX_KERNEL_SIDE,
	localparam int PIX_AW = $clog2(MAX_IMAGE_SIDE * MAX_IMAGE_SIDE),
	localparam int WGT_AW = (MAX_KERNEL_SIDE > 1) ?
		$clog2(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  c2d_pkg::cfg_t                      cfg,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [1:0]                         opcode,
	input  logic [5:0]                         row_index,
	input  logic [5:0]                         col_index,
	output logic                               pix_we,
	output logic [PIX_AW-1:0]                  pix_waddr,
	output logic                               pix_re,
	output logic [PIX_AW-1:0]                  pix_raddr,
	output logic                               wgt_we,
	output logic [WGT_AW-1:0]                  wgt_waddr,
	output logic                               wgt_re,
	output logic [WGT_AW-1:0]                  wgt_raddr,
	output c2d_pkg::mac_ctl_t                  mac_ctl,
	input  logic signed [c2d_pkg::SUM_BITS-1:0] acc,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [c2d_pkg::SUM_BITS-1:0] conv_sum,
	output logic                               status,
	output logic                               last_output
);

	import c2d_pkg::*;

	localparam int IW = $clog2(MAX_IMAGE_SIDE);
	localparam int SW = $clog2(MAX_IMAGE_SIDE + 1);
	localparam int KW = $clog2(MAX_KERNEL_SIDE + 1);
	localparam int NW = (SW + 2 > 11) ? SW + 2 : 11;
	// Drain count at which the accumulator holds the sum after the last tap read
	localparam logic [1:0] DRAIN_LAST = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_RUN   = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t state_q;

	logic [5:0]           row_q, col_q;
	logic [KW-1:0]        k_q, ki_q, kj_q;
	logic signed [NW-1:0] base_r_q, base_c_q;
	logic                 in_grid_q, last_q;
	logic [1:0]           drain_q;
	logic                 tap_s1;
	logic                 out_valid_q, status_q, last_output_q;
	logic signed [SUM_BITS-1:0] conv_sum_q;

	logic                 accept;
	logic [KW-1:0]        k_eff;
	logic [2:0]           s_eff;
	logic [SW-1:0]        rows_eff, cols_eff;
	logic signed [NW-1:0] num, rs, cs, rs1, cs1, pad_s, rows_s, cols_s, x, y;
	logic                 grid_ok, grid_last, tap_ok, last_tap, load;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// Effective configuration
	always_comb begin
		k_eff    = (int'(cfg.kernel_side) > MAX_KERNEL_SIDE) ?
			KW'(MAX_KERNEL_SIDE) : KW'(cfg.kernel_side);
		s_eff    = (cfg.step_size == 3'd0) ? 3'd1 : cfg.step_size;
		rows_eff = (cfg.image_rows == 7'd0 || int'(cfg.image_rows) > MAX_IMAGE_SIDE) ?
			SW'(MAX_IMAGE_SIDE) : SW'(cfg.image_rows);
		cols_eff = (cfg.image_cols == 7'd0 || int'(cfg.image_cols) > MAX_IMAGE_SIDE) ?
			SW'(MAX_IMAGE_SIDE) : SW'(cfg.image_cols);
	end

	// r < side is the same as r*stride <= numerator, so no divide is needed
	always_comb begin
		pad_s     = NW'(cfg.pad_width);
		rows_s    = NW'(rows_eff);
		cols_s    = NW'(cols_eff);
		num       = NW'(rows_eff) + NW'({cfg.pad_width, 1'b0}) - NW'(k_eff);
		rs        = NW'(row_q) * NW'(s_eff);
		cs        = NW'(col_q) * NW'(s_eff);
		rs1       = rs + NW'(s_eff);
		cs1       = cs + NW'(s_eff);
		grid_ok   = (num >= 0) && (rs <= num) && (cs <= num);
		grid_last = grid_ok && (rs1 > num) && (cs1 > num);
	end

	// Tap address generation
	always_comb begin
		x         = base_r_q + NW'(ki_q);
		y         = base_c_q + NW'(kj_q);
		tap_ok    = (x >= 0) && (x < rows_s) && (y >= 0) && (y < cols_s);
		last_tap  = (ki_q == k_q - KW'(1)) && (kj_q == k_q - KW'(1));
		pix_re    = (state_q == ST_RUN);
		wgt_re    = (state_q == ST_RUN);
		pix_raddr = PIX_AW'(x[IW-1:0]) * PIX_AW'(MAX_IMAGE_SIDE) + PIX_AW'(y[IW-1:0]);
		wgt_raddr = WGT_AW'(ki_q) * WGT_AW'(MAX_KERNEL_SIDE) + WGT_AW'(kj_q);
	end

	// Store writes happen in the accepting cycle
	always_comb begin
		pix_we    = accept && (opcode == OP_WR_PIXEL) &&
			(int'(row_index) < MAX_IMAGE_SIDE) && (int'(col_index) < MAX_IMAGE_SIDE);
		pix_waddr = PIX_AW'(row_index) * PIX_AW'(MAX_IMAGE_SIDE) + PIX_AW'(col_index);
		wgt_we    = accept && (opcode == OP_WR_WEIGHT) &&
			(int'(row_index) < MAX_KERNEL_SIDE) && (int'(col_index) < MAX_KERNEL_SIDE);
		wgt_waddr = WGT_AW'(row_index) * WGT_AW'(MAX_KERNEL_SIDE) + WGT_AW'(col_index);
	end

	assign mac_ctl.clear = (state_q == ST_CHECK);
	assign mac_ctl.valid = tap_s1;

	assign load = (state_q == ST_DRAIN) && (drain_q == DRAIN_LAST) &&
		(!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			ki_q    <= '0;
			kj_q    <= '0;
			drain_q <= '0;
			tap_s1  <= 1'b0;
		end else begin
			tap_s1 <= (state_q == ST_RUN) && tap_ok;
			case (state_q)
				ST_IDLE: begin
					if (accept && opcode == OP_COMPUTE) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					k_q     <= k_eff;
					ki_q    <= '0;
					kj_q    <= '0;
					drain_q <= '0;
					// skip the walk for an empty window or an off-grid query
					if (grid_ok && k_eff != '0) begin
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_DRAIN;
					end
				end
				ST_RUN: begin
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end else if (kj_q == k_q - KW'(1)) begin
						kj_q <= '0;
						ki_q <= ki_q + KW'(1);
					end else begin
						kj_q <= kj_q + KW'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q != DRAIN_LAST) begin
						drain_q <= drain_q + 2'd1;
					end else if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= row_index;
			col_q <= col_index;
		end
		if (state_q == ST_CHECK) begin
			base_r_q  <= rs - pad_s;
			base_c_q  <= cs - pad_s;
			in_grid_q <= grid_ok;
			last_q    <= grid_last;
		end
	end

	// Result register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			conv_sum_q    <= acc;
			status_q      <= !in_grid_q;
			last_output_q <= last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign conv_sum    = conv_sum_q;
	assign status      = status_q;
	assign last_output = last_output_q;

endmodule

FILE: src/conv2d_stride_pad_core.sv
// Top level of the 2D convolution engine with stride and zero padding.
`timescale 1ns / 1ps
// Usage:
//  Input channel (in_valid/in_stall) carries one transaction per item: opcode 0
//  writes a kernel weight, opcode 1 writes an image pixel, opcode 2 asks for
//  the output at (row_index, col_index) of the output grid. Opcode 3 is dropped.
//  Writes return nothing. A query returns one transaction on the output
//  channel (out_valid/out_stall): conv_sum, status, last_output. A query is
//  checked against the output grid, walks the K*K kernel taps and drains
//  before its result is loaded, where K is the effective kernel side; an
//  off-grid query or an empty kernel skips the walk. Throughput: one write
//  per cycle while in_stall is low. The kernel walk is set by the single
//  shared multiplier, one tap per cycle, behind registered-read stores. in_stall
//  stays high from a query's acceptance until the output register is loaded.
//  The output register holds its transaction while out_stall is high; a new
//  item is accepted meanwhile, and a later result waits until the register
//  frees up. Reset clears control state and sets the configuration registers
//  to their defaults; store contents are undefined until written.
//  Configuration (cfg_write/cfg_index/cfg_data) must be written only while idle; the block does not enforce this.

module conv2d_stride_pad_core #(
	parameter int MAX_IMAGE_SIDE  = c2d_pkg::DEF_MAX_IMAGE_SIDE,
	parameter int MAX_KERNEL_SIDE = c2d_pkg::DEF_MAX_KERNEL_SIDE,
	parameter int SAMPLE_BITS     = c2d_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [c2d_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [c2d_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          opcode,
	input  logic [5:0]                          row_index,
	input  logic [5:0]                          col_index,
	input  logic signed [SAMPLE_BITS-1:0]       sample_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [c2d_pkg::SUM_BITS-1:0] conv_sum,
	output logic                                status,
	output logic                                last_output
);

	import c2d_pkg::*;

	localparam int PIX_DEPTH = MAX_IMAGE_SIDE * MAX_IMAGE_SIDE;
	localparam int WGT_DEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
	localparam int PIX_AW    = $clog2(PIX_DEPTH);
	localparam int WGT_AW    = (MAX_KERNEL_SIDE > 1) ? $clog2(WGT_DEPTH) : 1;

	cfg_t     cfg_q;
	mac_ctl_t mac_ctl;

	logic                   pix_we, pix_re, wgt_we, wgt_re;
	logic [PIX_AW-1:0]      pix_waddr, pix_raddr;
	logic [WGT_AW-1:0]      wgt_waddr, wgt_raddr;
	logic [SAMPLE_BITS-1:0] pix_rdata, wgt_rdata;
	logic signed [SUM_BITS-1:0] acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kernel_side <= RST_KERNEL_SIDE;
			cfg_q.step_size   <= RST_STEP_SIZE;
			cfg_q.pad_width   <= RST_PAD_WIDTH;
			cfg_q.image_rows  <= RST_IMAGE_ROWS;
			cfg_q.image_cols  <= RST_IMAGE_COLS;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_KERNEL_SIDE: cfg_q.kernel_side <= cfg_data[2:0];
				CFG_STEP_SIZE:   cfg_q.step_size   <= cfg_data[2:0];
				CFG_PAD_WIDTH:   cfg_q.pad_width   <= cfg_data[1:0];
				CFG_IMAGE_ROWS:  cfg_q.image_rows  <= cfg_data;
				CFG_IMAGE_COLS:  cfg_q.image_cols  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	c2d_seq #(
		.MAX_IMAGE_SIDE  (MAX_IMAGE_SIDE),
		.MAX_KERNEL_SIDE (MAX_KERNEL_SIDE)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.row_index   (row_index),
		.col_index   (col_index),
		.pix_we      (pix_we),
		.pix_waddr   (pix_waddr),
		.pix_re      (pix_re),
		.pix_raddr   (pix_raddr),
		.wgt_we      (wgt_we),
		.wgt_waddr   (wgt_waddr),
		.wgt_re      (wgt_re),
		.wgt_raddr   (wgt_raddr),
		.mac_ctl     (mac_ctl),
		.acc         (acc),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.conv_sum    (conv_sum),
		.status      (status),
		.last_output (last_output)
	);

	c2d_ram #(
		.DEPTH (PIX_DEPTH),
		.WIDTH (SAMPLE_BITS),
		.AW    (PIX_AW)
	) u_pixel_store (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_waddr),
		.wdata (sample_value),
		.re    (pix_re),
		.raddr (pix_raddr),
		.rdata (pix_rdata)
	);

	c2d_ram #(
		.DEPTH (WGT_DEPTH),
		.WIDTH (SAMPLE_BITS),
		.AW    (WGT_AW)
	) u_weight_store (
		.clk   (clk),
		.we    (wgt_we),
		.waddr (wgt_waddr),
		.wdata (sample_value),
		.re    (wgt_re),
		.raddr (wgt_raddr),
		.rdata (wgt_rdata)
	);

	c2d_mac #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.pix    (pix_rdata),
		.wgt    (wgt_rdata),
		.acc    (acc)
	);

endmodule
